>>> rtl/ras_pkg.sv
package ras_pkg;

  localparam int KINDS = 7;
  localparam int SLOTS = 16;
  localparam int PEND_DEPTH = 16;
  localparam int MAX_COMMANDS = 30;
  localparam int SLOT_W = 4;
  localparam int CNT_W = 5;

  localparam logic [2:0] ST_STARTED  = 3'd0;
  localparam logic [2:0] ST_PENDING  = 3'd1;
  localparam logic [2:0] ST_REJECTED = 3'd2;
  localparam logic [2:0] ST_RELEASED = 3'd3;
  localparam logic [2:0] ST_BAD_SLOT = 3'd4;

  localparam logic OP_SUBMIT = 1'b0;

  typedef logic [KINDS-1:0][4:0] demand_t;
  typedef logic [KINDS-1:0][7:0] level_t;

  typedef struct packed {
    demand_t    demand;
    logic [5:0] client;
  } slot_rec_t;

  typedef struct packed {
    demand_t    demand;
    logic [5:0] client;
    logic [2:0] prio;
  } pend_rec_t;

  typedef struct packed {
    logic              claim;
    logic [SLOT_W-1:0] claim_idx;
    slot_rec_t         claim_rec;
    logic              release_en;
    logic [SLOT_W-1:0] rel_idx;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_idx;
  } slot_ctl_t;

  function automatic logic fits(level_t in_use, level_t limit, demand_t demand);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < KINDS; k++) begin
      if ({1'b0, in_use[k]} + {4'd0, demand[k]} > {1'b0, limit[k]}) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

>>> rtl/ras_queue_mem.sv
module ras_queue_mem (
  input  logic                     clk,
  input  logic                     we,
  input  logic [3:0]               waddr,
  input  ras_pkg::pend_rec_t       wdata,
  input  logic                     re,
  input  logic [3:0]               raddr,
  output ras_pkg::pend_rec_t       rdata
);

  ras_pkg::pend_rec_t mem [ras_pkg::PEND_DEPTH];
  ras_pkg::pend_rec_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/ras_slot_store.sv
module ras_slot_store (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ras_pkg::slot_ctl_t                ctl,
  output ras_pkg::slot_rec_t                rdata,
  output logic [ras_pkg::SLOTS-1:0]         busy,
  output logic                              free_found,
  output logic [ras_pkg::SLOT_W-1:0]        free_idx
);

  ras_pkg::slot_rec_t mem [ras_pkg::SLOTS];
  ras_pkg::slot_rec_t rdata_r;
  logic [ras_pkg::SLOTS-1:0] busy_r, busy_nxt;

  always_ff @(posedge clk) begin
    if (ctl.claim) mem[ctl.claim_idx] <= ctl.claim_rec;
    if (ctl.rd_en) rdata_r <= mem[ctl.rd_idx];
  end

  always_comb begin
    busy_nxt = busy_r;
    if (ctl.release_en) busy_nxt[ctl.rel_idx] = 1'b0;
    if (ctl.claim) busy_nxt[ctl.claim_idx] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int s = ras_pkg::SLOTS - 1; s >= 0; s--) begin
      if (!busy_r[s]) begin
        free_found = 1'b1;
        free_idx = ras_pkg::SLOT_W'(s);
      end
    end
  end

  assign rdata = rdata_r;
  assign busy = busy_r;

endmodule

>>> rtl/resource_admission_scheduler.sv
// a submit that starts or is rejected at once, or a finish of a free slot, yields a single result;
// a queued submit first scans the queue for its place, then moves the entries behind it up one.
// a finish of a busy slot releases it, then visits each queue entry, starts each one that fits
// the limits and a free slot, and closes the gap it leaves; output stalls can hold these steps.
// one request at a time: in_stall is high until the last result has been loaded for output.
// rst_n is synchronous: clears limits, in-use counts, busy slots, queue count and handshake.
module resource_admission_scheduler (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_opcode,
  input  logic [5:0] in_client_id,
  input  logic [2:0] in_priority_req,
  input  logic [3:0] in_finish_slot,
  input  logic [4:0] in_count_nop,
  input  logic [4:0] in_count_bcompress,
  input  logic [4:0] in_count_bdecompress,
  input  logic [4:0] in_count_gcompress,
  input  logic [4:0] in_count_gdecompress,
  input  logic [4:0] in_count_encrypt,
  input  logic [4:0] in_count_decrypt,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [5:0] out_result_client,
  output logic [3:0] out_result_slot,
  output logic       out_last
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SUB    = 4'd1;
  localparam logic [3:0] S_FIND   = 4'd2;
  localparam logic [3:0] S_FINDW  = 4'd3;
  localparam logic [3:0] S_SHUP   = 4'd4;
  localparam logic [3:0] S_SHUPW  = 4'd5;
  localparam logic [3:0] S_FIN    = 4'd6;
  localparam logic [3:0] S_FINW   = 4'd7;
  localparam logic [3:0] S_WALK   = 4'd8;
  localparam logic [3:0] S_WALKW  = 4'd9;
  localparam logic [3:0] S_SHDN   = 4'd10;
  localparam logic [3:0] S_SHDNW  = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  localparam int CW = ras_pkg::CNT_W;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] client;
    logic [3:0] slot;
  } res_t;

  logic [3:0] state_r, state_nxt;
  logic [5:0] client_r;
  logic [2:0] prio_r;
  logic [3:0] fs_r;
  ras_pkg::demand_t dem_r;
  ras_pkg::level_t  in_use_r, in_use_nxt, limit_r;
  logic [CW-1:0] cnt_r, cnt_nxt, z_r, z_nxt, j_r, j_nxt, pos_r, pos_nxt;
  res_t hold_r, hold_nxt;
  logic hold_v_r, hold_v_nxt;
  logic out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  res_t out_res_r, out_res_nxt;

  logic out_free, can_emit, emit;
  res_t emit_res;

  logic q_we, q_re;
  logic [3:0] q_waddr, q_raddr;
  ras_pkg::pend_rec_t q_wdata, q_rdata;

  ras_pkg::slot_ctl_t slot_ctl;
  ras_pkg::slot_rec_t s_rdata;
  logic [ras_pkg::SLOTS-1:0] busy;
  logic free_found;
  logic [3:0] free_idx;
  logic [7:0] total;

  ras_queue_mem u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  ras_slot_store u_slots (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (slot_ctl),
    .rdata      (s_rdata),
    .busy       (busy),
    .free_found (free_found),
    .free_idx   (free_idx)
  );

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign can_emit = !hold_v_r || out_free;

  always_comb begin
    total = '0;
    for (int k = 0; k < ras_pkg::KINDS; k++) total = total + {3'd0, dem_r[k]};
  end

  always_comb begin
    state_nxt = state_r;
    in_use_nxt = in_use_r;
    cnt_nxt = cnt_r;
    z_nxt = z_r;
    j_nxt = j_r;
    pos_nxt = pos_r;
    emit = 1'b0;
    emit_res = '0;
    q_we = 1'b0;
    q_re = 1'b0;
    q_waddr = z_r[3:0];
    q_raddr = z_r[3:0];
    q_wdata = q_rdata;
    slot_ctl = '0;
    slot_ctl.claim_idx = free_idx;
    slot_ctl.rel_idx = fs_r;
    slot_ctl.rd_idx = fs_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = (in_opcode == ras_pkg::OP_SUBMIT) ? S_SUB : S_FIN;
      end
      S_SUB: begin
        if (can_emit) begin
          if (total > 8'(ras_pkg::MAX_COMMANDS)) begin
            emit = 1'b1;
            emit_res = '{ras_pkg::ST_REJECTED, client_r, 4'd0};
            state_nxt = S_DONE;
          end else if (ras_pkg::fits(in_use_r, limit_r, dem_r) && free_found) begin
            emit = 1'b1;
            emit_res = '{ras_pkg::ST_STARTED, client_r, free_idx};
            slot_ctl.claim = 1'b1;
            slot_ctl.claim_rec = '{dem_r, client_r};
            for (int k = 0; k < ras_pkg::KINDS; k++) in_use_nxt[k] = in_use_r[k] + {3'd0, dem_r[k]};
            state_nxt = S_DONE;
          end else if (cnt_r >= CW'(ras_pkg::PEND_DEPTH)) begin
            emit = 1'b1;
            emit_res = '{ras_pkg::ST_REJECTED, client_r, 4'd0};
            state_nxt = S_DONE;
          end else begin
            z_nxt = '0;
            state_nxt = S_FIND;
          end
        end
      end
      // find first entry of lower priority
      S_FIND: begin
        if (z_r == cnt_r) begin
          pos_nxt = cnt_r;
          state_nxt = S_SHUP;
        end else begin
          q_re = 1'b1;
          state_nxt = S_FINDW;
        end
      end
      S_FINDW: begin
        if (q_rdata.prio < prio_r) begin
          pos_nxt = z_r;
          z_nxt = cnt_r;
          state_nxt = S_SHUP;
        end else begin
          z_nxt = z_r + 1'b1;
          state_nxt = S_FIND;
        end
      end
      S_SHUP: begin
        if (z_r == pos_r) begin
          if (can_emit) begin
            q_we = 1'b1;
            q_wdata = '{dem_r, client_r, prio_r};
            cnt_nxt = cnt_r + 1'b1;
            emit = 1'b1;
            emit_res = '{ras_pkg::ST_PENDING, client_r, 4'd0};
            state_nxt = S_DONE;
          end
        end else begin
          q_re = 1'b1;
          q_raddr = 4'(z_r - 1'b1);
          state_nxt = S_SHUPW;
        end
      end
      S_SHUPW: begin
        q_we = 1'b1;
        z_nxt = z_r - 1'b1;
        state_nxt = S_SHUP;
      end
      S_FIN: begin
        if (!busy[fs_r]) begin
          if (can_emit) begin
            emit = 1'b1;
            emit_res = '{ras_pkg::ST_BAD_SLOT, 6'd0, fs_r};
            state_nxt = S_DONE;
          end
        end else begin
          slot_ctl.rd_en = 1'b1;
          state_nxt = S_FINW;
        end
      end
      S_FINW: begin
        if (can_emit) begin
          emit = 1'b1;
          emit_res = '{ras_pkg::ST_RELEASED, s_rdata.client, fs_r};
          slot_ctl.release_en = 1'b1;
          for (int k = 0; k < ras_pkg::KINDS; k++) begin
            in_use_nxt[k] = (in_use_r[k] >= {3'd0, s_rdata.demand[k]}) ?
                            in_use_r[k] - {3'd0, s_rdata.demand[k]} : 8'd0;
          end
          j_nxt = '0;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (j_r >= cnt_r) begin
          state_nxt = S_DONE;
        end else begin
          q_re = 1'b1;
          q_raddr = j_r[3:0];
          state_nxt = S_WALKW;
        end
      end
      S_WALKW: begin
        if (ras_pkg::fits(in_use_r, limit_r, q_rdata.demand) && free_found) begin
          if (can_emit) begin
            emit = 1'b1;
            emit_res = '{ras_pkg::ST_STARTED, q_rdata.client, free_idx};
            slot_ctl.claim = 1'b1;
            slot_ctl.claim_rec = '{q_rdata.demand, q_rdata.client};
            for (int k = 0; k < ras_pkg::KINDS; k++) begin
              in_use_nxt[k] = in_use_r[k] + {3'd0, q_rdata.demand[k]};
            end
            z_nxt = j_r;
            state_nxt = S_SHDN;
          end
        end else begin
          j_nxt = j_r + 1'b1;
          state_nxt = S_WALK;
        end
      end
      // close the gap left by a started entry
      S_SHDN: begin
        if (z_r + 1'b1 >= cnt_r) begin
          cnt_nxt = cnt_r - 1'b1;
          state_nxt = S_WALK;
        end else begin
          q_re = 1'b1;
          q_raddr = 4'(z_r + 1'b1);
          state_nxt = S_SHDNW;
        end
      end
      S_SHDNW: begin
        q_we = 1'b1;
        z_nxt = z_r + 1'b1;
        state_nxt = S_SHDN;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // one result is held back so the final one can be marked last
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_res_nxt = out_res_r;
    out_last_nxt = out_last_r;
    hold_nxt = hold_r;
    hold_v_nxt = hold_v_r;
    if (emit) begin
      if (hold_v_r) begin
        out_valid_nxt = 1'b1;
        out_res_nxt = hold_r;
        out_last_nxt = 1'b0;
      end
      hold_nxt = emit_res;
      hold_v_nxt = 1'b1;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_nxt = 1'b1;
      out_res_nxt = hold_r;
      out_last_nxt = 1'b1;
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      in_use_r <= '0;
      limit_r <= '0;
      cnt_r <= '0;
      hold_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      in_use_r <= in_use_nxt;
      cnt_r <= cnt_nxt;
      hold_v_r <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index < 3'(ras_pkg::KINDS)) limit_r[cfg_index] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    z_r <= z_nxt;
    j_r <= j_nxt;
    pos_r <= pos_nxt;
    hold_r <= hold_nxt;
    out_res_r <= out_res_nxt;
    out_last_r <= out_last_nxt;
    if (state_r == S_IDLE && in_valid) begin
      client_r <= in_client_id;
      prio_r <= in_priority_req;
      fs_r <= in_finish_slot;
      dem_r <= {in_count_decrypt, in_count_encrypt, in_count_gdecompress,
                in_count_gcompress, in_count_bdecompress, in_count_bcompress,
                in_count_nop};
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_res_r.status;
  assign out_result_client = out_res_r.client;
  assign out_result_slot = out_res_r.slot;
  assign out_last = out_last_r;

endmodule

>>> sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic       op;
    logic [5:0] client;
    logic [2:0] prio;
    logic [3:0] fslot;
    ras_pkg::demand_t dem;
  } req_t;

  typedef struct packed {
    logic [2:0] st;
    logic [5:0] client;
    logic [3:0] slot;
    logic       lst;
  } res_t;

  // directed row: either a request or a write of every limit to one value
  typedef struct packed {
    logic       set_limits;
    logic [7:0] limit_val;
    req_t       rq;
    logic       typed;
    logic [2:0] typed_st;
    logic [3:0] typed_slot;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = 0;
  logic [7:0] cfg_wdata = 0;
  logic in_valid = 0;
  logic in_stall;
  logic in_opcode = 0;
  logic [5:0] in_client_id = 0;
  logic [2:0] in_priority_req = 0;
  logic [3:0] in_finish_slot = 0;
  logic [4:0] in_count_nop = 0, in_count_bcompress = 0, in_count_bdecompress = 0;
  logic [4:0] in_count_gcompress = 0, in_count_gdecompress = 0;
  logic [4:0] in_count_encrypt = 0, in_count_decrypt = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] out_status;
  logic [5:0] out_result_client;
  logic [3:0] out_result_slot;
  logic out_last;

  resource_admission_scheduler uut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // scheduler model
  ras_pkg::level_t    lim_m, used_m;
  logic               busy_m [ras_pkg::SLOTS];
  ras_pkg::demand_t   sdem_m [ras_pkg::SLOTS];
  logic [5:0]         scl_m [ras_pkg::SLOTS];
  ras_pkg::demand_t   pdem_m [ras_pkg::PEND_DEPTH];
  logic [5:0]         pcl_m [ras_pkg::PEND_DEPTH];
  logic [2:0]         ppr_m [ras_pkg::PEND_DEPTH];
  int                 pend_n;

  res_t expected_results[$];
  int   errors = 0;
  int   cycles = 0;
  bit   quiet = 0;
  int   stall_left = 0;

  function automatic bit room_for(ras_pkg::demand_t d);
    for (int k = 0; k < ras_pkg::KINDS; k++)
      if (int'(used_m[k]) + int'(d[k]) > int'(lim_m[k])) return 0;
    return 1;
  endfunction

  function automatic void push_result(logic [2:0] st, logic [5:0] cl, logic [3:0] sl);
    res_t r;
    r.st = st; r.client = cl; r.slot = sl; r.lst = 0;
    expected_results.push_back(r);
  endfunction

  function automatic bit admit(ras_pkg::demand_t d, logic [5:0] cl);
    int s;
    s = -1;
    if (!room_for(d)) return 0;
    for (int i = ras_pkg::SLOTS - 1; i >= 0; i--) if (!busy_m[i]) s = i;
    if (s < 0) return 0;
    for (int k = 0; k < ras_pkg::KINDS; k++) used_m[k] = used_m[k] + d[k];
    sdem_m[s] = d;
    scl_m[s] = cl;
    busy_m[s] = 1;
    push_result(ras_pkg::ST_STARTED, cl, s[3:0]);
    return 1;
  endfunction

  function automatic void schedule(req_t r);
    int total, pos, j;
    ras_pkg::demand_t d;
    total = 0;
    if (r.op == ras_pkg::OP_SUBMIT) begin
      for (int k = 0; k < ras_pkg::KINDS; k++) total += r.dem[k];
      if (total > ras_pkg::MAX_COMMANDS) begin
        push_result(ras_pkg::ST_REJECTED, r.client, 4'd0);
      end else if (admit(r.dem, r.client)) begin
      end else if (pend_n >= ras_pkg::PEND_DEPTH) begin
        push_result(ras_pkg::ST_REJECTED, r.client, 4'd0);
      end else begin
        pos = pend_n;
        for (int z = 0; z < pend_n; z++)
          if (ppr_m[z] < r.prio) begin
            pos = z;
            break;
          end
        for (int z = pend_n; z > pos; z--) begin
          pdem_m[z] = pdem_m[z-1]; pcl_m[z] = pcl_m[z-1]; ppr_m[z] = ppr_m[z-1];
        end
        pdem_m[pos] = r.dem; pcl_m[pos] = r.client; ppr_m[pos] = r.prio;
        pend_n++;
        push_result(ras_pkg::ST_PENDING, r.client, 4'd0);
      end
    end else if (!busy_m[r.fslot]) begin
      push_result(ras_pkg::ST_BAD_SLOT, 6'd0, r.fslot);
    end else begin
      d = sdem_m[r.fslot];
      for (int k = 0; k < ras_pkg::KINDS; k++)
        used_m[k] = (used_m[k] >= d[k]) ? used_m[k] - d[k] : 8'd0;
      busy_m[r.fslot] = 0;
      push_result(ras_pkg::ST_RELEASED, scl_m[r.fslot], r.fslot);
      j = 0;
      while (j < pend_n) begin
        if (admit(pdem_m[j], pcl_m[j])) begin
          for (int z = j; z + 1 < pend_n; z++) begin
            pdem_m[z] = pdem_m[z+1]; pcl_m[z] = pcl_m[z+1]; ppr_m[z] = ppr_m[z+1];
          end
          pend_n--;
        end else begin
          j++;
        end
      end
    end
    expected_results[expected_results.size()-1].lst = 1;
  endfunction

  task automatic send_request(req_t r);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_opcode = r.op;
    in_client_id = r.client;
    in_priority_req = r.prio;
    in_finish_slot = r.fslot;
    {in_count_decrypt, in_count_encrypt, in_count_gdecompress, in_count_gcompress,
     in_count_bdecompress, in_count_bcompress, in_count_nop} = r.dem;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    schedule(r);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_limit(int idx, logic [7:0] val);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx[2:0];
    cfg_wdata = val;
    lim_m[idx] = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  function automatic req_t random_task();
    req_t r;
    int s;
    r = '0;
    r.client = 6'($urandom_range(0, 63));
    r.prio = 3'($urandom_range(0, 7));
    r.fslot = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 9) < 4) begin
      r.op = 1;
      if ($urandom_range(0, 9) != 0) begin
        s = $urandom_range(0, ras_pkg::SLOTS - 1);
        for (int i = 0; i < ras_pkg::SLOTS; i++)
          if (busy_m[(s + i) % ras_pkg::SLOTS]) begin
            r.fslot = 4'((s + i) % ras_pkg::SLOTS);
            break;
          end
      end
    end else begin
      r.op = 0;
      for (int k = 0; k < ras_pkg::KINDS; k++)
        r.dem[k] = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                : 5'($urandom_range(0, 4));
    end
    return r;
  endfunction

  function automatic row_t req_row(logic op, logic [5:0] cl, logic [2:0] pr, logic [3:0] fs,
                                   ras_pkg::demand_t d, logic ty, logic [2:0] tst,
                                   logic [3:0] tsl);
    row_t w;
    w = '0;
    w.rq.op = op; w.rq.client = cl; w.rq.prio = pr; w.rq.fslot = fs; w.rq.dem = d;
    w.typed = ty; w.typed_st = tst; w.typed_slot = tsl;
    return w;
  endfunction

  function automatic row_t limit_row(logic [7:0] v);
    row_t w;
    w = '0;
    w.set_limits = 1;
    w.limit_val = v;
    return w;
  endfunction

  // monitor
  always @(posedge clk) begin
    res_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result st=%0d client=%0d slot=%0d", $time,
                 out_status, out_result_client, out_result_slot);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_status !== e.st || out_result_client !== e.client ||
            out_result_slot !== e.slot || out_last !== e.lst) begin
          $display("%0t: mismatch exp st=%0d client=%0d slot=%0d last=%0d", $time,
                   e.st, e.client, e.slot, e.lst);
          $display("%0t:          got st=%0d client=%0d slot=%0d last=%0d", $time,
                   out_status, out_result_client, out_result_slot, out_last);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (quiet || !rst_n) begin
      out_stall = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall = 1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      out_stall = 1;
    end else begin
      out_stall = 0;
    end
  end

  initial begin
    row_t rows[$];
    res_t newest;
    lim_m = '0;
    used_m = '0;
    pend_n = 0;
    for (int i = 0; i < ras_pkg::SLOTS; i++) busy_m[i] = 0;

    // all limits zero after reset: only empty demands fit
    rows.push_back(req_row(1, 0, 0, 0, '0, 1, ras_pkg::ST_BAD_SLOT, 0));
    rows.push_back(req_row(1, 0, 0, 15, '0, 1, ras_pkg::ST_BAD_SLOT, 15));
    rows.push_back(req_row(0, 63, 7, 0, {ras_pkg::KINDS{5'd31}}, 1, ras_pkg::ST_REJECTED, 0));
    rows.push_back(req_row(0, 1, 0, 0, {5'd1, {6{5'd5}}}, 1, ras_pkg::ST_REJECTED, 0));
    rows.push_back(req_row(0, 63, 7, 0, '0, 1, ras_pkg::ST_STARTED, 0));
    rows.push_back(req_row(0, 2, 0, 0, {5'd0, {6{5'd5}}}, 1, ras_pkg::ST_PENDING, 0));
    rows.push_back(req_row(0, 3, 5, 0, 35'd1, 1, ras_pkg::ST_PENDING, 0));
    rows.push_back(req_row(0, 4, 5, 0, {5'd30, 30'd0}, 1, ras_pkg::ST_PENDING, 0));
    rows.push_back(req_row(0, 5, 7, 0, {30'd0, 5'd2}, 1, ras_pkg::ST_PENDING, 0));
    rows.push_back(req_row(0, 6, 6, 0, {5'd0, 5'd3, 25'd0}, 1, ras_pkg::ST_PENDING, 0));
    rows.push_back(req_row(1, 0, 0, 1, '0, 1, ras_pkg::ST_BAD_SLOT, 1));
    // release with limits still zero: nothing queued fits
    rows.push_back(req_row(1, 0, 0, 0, '0, 0, 0, 0));
    rows.push_back(limit_row(8'd255));
    // finish of an empty task releases nothing; queue is walked and all start
    rows.push_back(req_row(0, 7, 1, 0, '0, 0, 0, 0));
    rows.push_back(req_row(1, 0, 0, 0, '0, 0, 0, 0));
    rows.push_back(req_row(1, 0, 0, 3, '0, 0, 0, 0));
    rows.push_back(limit_row(8'd3));
    rows.push_back(req_row(0, 8, 2, 0, 35'd4, 0, 0, 0));
    rows.push_back(req_row(0, 9, 4, 0, 35'd3, 0, 0, 0));
    rows.push_back(req_row(1, 0, 0, 2, '0, 0, 0, 0));
    rows.push_back(req_row(1, 0, 0, 1, '0, 0, 0, 0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    foreach (rows[i]) begin
      if (rows[i].set_limits) begin
        drain();
        for (int k = 0; k < ras_pkg::KINDS; k++) write_limit(k, rows[i].limit_val);
      end else begin
        send_request(rows[i].rq);
        // earlier results may still wait in the queue, so look at the newest one
        newest = expected_results[expected_results.size()-1];
        if (rows[i].typed && (newest.st !== rows[i].typed_st ||
                              newest.slot !== rows[i].typed_slot)) begin
          $display("%0t: row %0d predicted st=%0d slot=%0d, table says st=%0d slot=%0d",
                   $time, i, newest.st, newest.slot,
                   rows[i].typed_st, rows[i].typed_slot);
          errors++;
        end
      end
    end

    // random phases under different limit settings
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      for (int k = 0; k < ras_pkg::KINDS; k++) begin
        case (ph)
          0: write_limit(k, 8'($urandom_range(4, 20)));
          1: write_limit(k, (k == 3) ? 8'd0 : 8'($urandom_range(2, 12)));
          2: write_limit(k, 8'($urandom_range(0, 255)));
          3: write_limit(k, 8'($urandom_range(1, 6)));
          default: write_limit(k, 8'd255);
        endcase
      end
      if (ph == 4) quiet = 1;
      for (int n = 0; n < 80; n++) send_request(random_task());
    end

    drain();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
rtl/ras_pkg.sv
rtl/ras_queue_mem.sv
rtl/ras_slot_store.sv
rtl/resource_admission_scheduler.sv
sim/tb_top.sv
